/* hw/rtl/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int BBA_MAP_BYTES = 32;   // default map size in bytes
	localparam int BBA_MAX_BYTES = 63;   // largest byte count the count register can name
	localparam int BASE_W        = 32;
	localparam int BSIZE_W       = 16;
	localparam int BIU_W         = 6;
	localparam int ADDR_W        = 33;
	localparam int NUM_W         = 9;    // block numbers below eight times the byte count
	localparam int IDX_W         = 8;
	localparam int PROD_W        = NUM_W + BSIZE_W;
	localparam int DIV_K_W       = 4;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 32;

	localparam logic [BSIZE_W-1:0] BSIZE_RST = 16'd64;
	localparam logic [BIU_W-1:0]   BIU_RST   = 6'd32;
	localparam logic [7:0]         BYTE_FULL = 8'hFF;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_TEST  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BELOW   = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE         = 2'd0,
		REG_BLOCK_SIZE   = 2'd1,
		REG_BYTES_IN_USE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIVIDE,
		S_LOOKUP,
		S_MODIFY,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic capture;       // latch the request fields
		logic decode;        // classify the request, set early status
		logic rd;            // read one map byte
		logic rd_sel_num;    // read address from the block number register
		logic div_step;      // one quotient bit of the free divider
		logic lookup_fault;  // quotient past the map
		logic modify;        // update the byte or sample the tested bit
		logic emit;          // drive the result for one cycle
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic fault;
		logic div_last;
		logic num_oor;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
// Sequencing controller of the bitmap block allocator.
// Depends on bba_pkg; drives the datapath through dp_cmd_t and watches dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  cmd
);
	import bba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.fault) state_d = S_FINISH;
				else if (stat.is_free) state_d = S_DIVIDE;
				else state_d = S_MODIFY;
			end
			S_DIVIDE: begin
				if (stat.div_last) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (stat.num_oor) state_d = S_FINISH;
				else state_d = S_MODIFY;
			end
			S_MODIFY: state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				cmd.rd     = !stat.fault && !stat.is_free;
			end
			S_DIVIDE: cmd.div_step = 1'b1;
			S_LOOKUP: begin
				cmd.lookup_fault = stat.num_oor;
				cmd.rd           = !stat.num_oor;
				cmd.rd_sel_num   = 1'b1;
			end
			S_MODIFY: cmd.modify = 1'b1;
			S_FINISH: cmd.emit   = 1'b1;
			default:  cmd        = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/bba_datapath.sv */
// Datapath of the bitmap block allocator: map memory, full flags, free divider
// and result registers. Depends on bba_pkg; commanded by bba_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath #(
	parameter int MAP_BYTES = bba_pkg::BBA_MAP_BYTES
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  bba_pkg::dp_cmd_t             cmd,
	output bba_pkg::dp_stat_t            stat,
	input  wire [1:0]                    opcode,
	input  wire [bba_pkg::ADDR_W-1:0]    address,
	input  wire [bba_pkg::IDX_W-1:0]     block_index,
	input  wire [bba_pkg::BASE_W-1:0]    base_address,
	input  wire [bba_pkg::BSIZE_W-1:0]   block_size,
	input  wire [bba_pkg::BIU_W-1:0]     bytes_in_use,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [bba_pkg::ADDR_W-1:0]   block_address,
	output logic [bba_pkg::IDX_W-1:0]    block_number,
	output logic                         bit_value
);
	import bba_pkg::*;

	// The byte count register cannot reach past its own range, so bytes above it never matter.
	localparam int USED_BYTES = (MAP_BYTES < BBA_MAX_BYTES) ? MAP_BYTES : BBA_MAX_BYTES;
	localparam int BYTE_AW    = (USED_BYTES > 1) ? $clog2(USED_BYTES) : 1;
	localparam logic [BIU_W-1:0] USED_BYTES_V = BIU_W'(USED_BYTES);

	// Request and working registers.
	logic [1:0]          op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [IDX_W-1:0]    tidx_q;
	status_t             st_q;
	logic [NUM_W-1:0]    num_q;
	logic                bit_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   rem_q;
	logic [DIV_K_W-1:0]  div_k_q;

	// Map storage.
	logic [7:0]          mem [USED_BYTES];
	logic [USED_BYTES-1:0] vld_q;
	logic [USED_BYTES-1:0] full_q;
	logic [7:0]          rd_data_q;
	logic                rd_vld_q;
	logic [BYTE_AW-1:0]  rd_addr_q;

	// Decode-time logic.
	logic [BIU_W-1:0]    nbytes;
	logic [NUM_W-1:0]    nblocks;
	logic [USED_BYTES-1:0] cand;
	logic [BIU_W-1:0]    alloc_byte;
	logic                found;
	logic                below;
	logic [ADDR_W-1:0]   diff;
	logic                div_ovf;
	logic                test_oor;
	logic [BIU_W-1:0]    rd_byte;
	logic [BYTE_AW-1:0]  rd_addr;

	// Divider step.
	logic [PROD_W-1:0]   div_sub;
	logic                div_ge;

	// Byte update.
	logic [7:0]          byte_val;
	logic [2:0]          zero_bit;
	logic [NUM_W-1:0]    alloc_num;
	logic [7:0]          bit_mask;
	logic [7:0]          new_byte;

	assign nbytes  = (bytes_in_use > USED_BYTES_V) ? USED_BYTES_V : bytes_in_use;
	assign nblocks = {nbytes, 3'b000};

	always_comb begin
		for (int i = 0; i < USED_BYTES; i++) begin
			cand[i] = !full_q[i] && (BIU_W'(i) < nbytes);
		end
		alloc_byte = '0;
		for (int i = USED_BYTES - 1; i >= 0; i--) begin
			if (cand[i]) alloc_byte = BIU_W'(i);
		end
		found = |cand;
	end

	assign below    = addr_q < {1'b0, base_address};
	assign diff     = addr_q - {1'b0, base_address};
	// A zero block size also lands here: every offset is at or past zero.
	assign div_ovf  = diff >= {{(ADDR_W - PROD_W){1'b0}}, block_size, {NUM_W{1'b0}}};
	assign test_oor = {1'b0, tidx_q} >= nblocks;

	always_comb begin
		stat.is_free  = (op_q == OP_FREE);
		stat.div_last = (div_k_q == '0);
		stat.num_oor  = (num_q >= nblocks);
		case (op_q)
			OP_ALLOC: stat.fault = !found;
			OP_FREE:  stat.fault = below || div_ovf;
			OP_TEST:  stat.fault = test_oor;
			default:  stat.fault = 1'b1;
		endcase
	end

	always_comb begin
		if (cmd.rd_sel_num) rd_byte = num_q[NUM_W-1:3];
		else if (op_q == OP_ALLOC) rd_byte = alloc_byte;
		else rd_byte = {1'b0, tidx_q[IDX_W-1:3]};
	end
	assign rd_addr = rd_byte[BYTE_AW-1:0];

	assign div_sub = {{NUM_W{1'b0}}, block_size} << div_k_q;
	assign div_ge  = rem_q >= div_sub;

	assign byte_val = rd_vld_q ? rd_data_q : 8'h00;

	always_comb begin
		zero_bit = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (!byte_val[b]) zero_bit = 3'(b);
		end
		alloc_num = {num_q[NUM_W-1:3], zero_bit};
		if (op_q == OP_ALLOC) begin
			bit_mask = 8'h01 << zero_bit;
			new_byte = byte_val | bit_mask;
		end else begin
			bit_mask = 8'h01 << num_q[2:0];
			new_byte = byte_val & ~bit_mask;
		end
	end

	// Request capture, classification, division and byte update.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			addr_q <= address;
			tidx_q <= block_index;
		end
		if (cmd.decode) begin
			bit_q <= 1'b0;
			case (op_q)
				OP_ALLOC: begin
					st_q  <= found ? ST_OK : ST_NOSPACE;
					num_q <= {alloc_byte, 3'b000};
				end
				OP_FREE: begin
					if (below) st_q <= ST_BELOW;
					else if (div_ovf) st_q <= ST_RANGE;
					else st_q <= ST_OK;
					num_q   <= '0;
					rem_q   <= diff[PROD_W-1:0];
					div_k_q <= DIV_K_W'(NUM_W - 1);
				end
				OP_TEST: begin
					st_q  <= test_oor ? ST_RANGE : ST_OK;
					num_q <= {1'b0, tidx_q};
				end
				default: st_q <= ST_RANGE;
			endcase
		end
		if (cmd.div_step) begin
			num_q[div_k_q] <= div_ge;
			if (div_ge) rem_q <= rem_q - div_sub;
			if (div_k_q != '0) div_k_q <= div_k_q - DIV_K_W'(1);
		end
		if (cmd.lookup_fault) st_q <= ST_RANGE;
		if (cmd.modify) begin
			case (op_q)
				OP_ALLOC: begin
					num_q  <= alloc_num;
					prod_q <= PROD_W'(alloc_num) * PROD_W'(block_size);
				end
				OP_TEST: bit_q <= byte_val[num_q[2:0]];
				default: bit_q <= 1'b0;
			endcase
		end
	end

	// Map memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (cmd.modify && (op_q != OP_TEST)) mem[rd_addr_q] <= new_byte;
	end

	// Valid and full flags clear at reset; an unwritten byte reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			full_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.rd) rd_vld_q <= vld_q[rd_addr];
			if (cmd.modify && (op_q != OP_TEST)) begin
				vld_q[rd_addr_q]  <= 1'b1;
				full_q[rd_addr_q] <= (new_byte == BYTE_FULL);
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status       <= st_q;
			block_number <= (st_q == ST_OK) ? num_q[IDX_W-1:0] : '0;
			bit_value    <= bit_q;
			if ((op_q == OP_ALLOC) && (st_q == ST_OK)) begin
				block_address <= {1'b0, base_address} +
					{{(ADDR_W - PROD_W){1'b0}}, prod_q};
			end else begin
				block_address <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bitmap_block_allocator_core.sv */
// Top level of the bitmap block allocator: configuration registers on an APB-style
// port, plus the controller and datapath. Depends on bba_pkg, bba_ctrl, bba_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block hands out fixed-size blocks of a memory region that starts at
// base_address. A request is taken at a rising edge where start is high and busy
// is low; opcode chooses allocate, free by address or test of one block's bit.
// Each request produces exactly one result, shown for a single cycle with done
// high. The receiver cannot hold results off, so nothing ever waits at the output.
// A successful allocate or test request passes the decode, modify and finish states
// before the next one is taken, with done high in the cycle in which busy falls. A
// free request also passes the divider, which produces one quotient bit per cycle
// over the nine bits of a block number, then the lookup. A request that fails when
// first classified (no free block, below base, an offset far past the map or a zero
// block size, a test index past the map, or an unused opcode) goes straight to
// its result, as does a free whose quotient lands past the map at the lookup.
// The lowest free block is found by a priority encoder over one full flag per map
// byte, followed by a read of that byte from the map memory. Reset clears every
// used bit at once through per-byte valid flags, so requests are taken in the first
// cycle after reset; the registers return to base 0, block size 64 and 32 bytes in
// use. Registers sit at byte addresses 0, 4 and 8, are written in the APB access
// cycle, and should be changed only while no request is in progress.

module bitmap_block_allocator_core #(
	parameter int MAP_BYTES = bba_pkg::BBA_MAP_BYTES
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire [1:0]                   opcode,
	input  wire [bba_pkg::ADDR_W-1:0]   address,
	input  wire [bba_pkg::IDX_W-1:0]    block_index,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [bba_pkg::ADDR_W-1:0]  block_address,
	output logic [bba_pkg::IDX_W-1:0]   block_number,
	output logic                        bit_value,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [bba_pkg::APB_AW-1:0]   paddr,
	input  wire [bba_pkg::APB_DW-1:0]   pwdata,
	output logic [bba_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import bba_pkg::*;

	logic [BASE_W-1:0]  base_q;
	logic [BSIZE_W-1:0] bsize_q;
	logic [BIU_W-1:0]   biu_q;
	logic               cfg_wr;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Registers are word-aligned; the low address bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bsize_q <= BSIZE_RST;
			biu_q   <= BIU_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BASE:         base_q  <= pwdata[BASE_W-1:0];
				REG_BLOCK_SIZE:   bsize_q <= pwdata[BSIZE_W-1:0];
				REG_BYTES_IN_USE: biu_q   <= pwdata[BIU_W-1:0];
				default:          base_q  <= base_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BASE:         prdata = base_q;
			REG_BLOCK_SIZE:   prdata = {{(APB_DW - BSIZE_W){1'b0}}, bsize_q};
			REG_BYTES_IN_USE: prdata = {{(APB_DW - BIU_W){1'b0}}, biu_q};
			default:          prdata = '0;
		endcase
	end

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bba_datapath #(
		.MAP_BYTES (MAP_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.address       (address),
		.block_index   (block_index),
		.base_address  (base_q),
		.block_size    (bsize_q),
		.bytes_in_use  (biu_q),
		.done          (done),
		.status        (status),
		.block_address (block_address),
		.block_number  (block_number),
		.bit_value     (bit_value)
	);

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for bitmap_block_allocator_core: directed and random allocate, free
// and test requests are checked against a used-block bitmap tracked inside the bench.
// Depends on bba_pkg and the RTL of the allocator core; reads no files.

module testbench;
	import bba_pkg::*;

	localparam int         MAP_BLOCKS     = BBA_MAP_BYTES * 8;
	localparam logic [1:0] OPC_UNUSED     = 2'd3;   // opcode with no operation behind it
	localparam int         RANDOM_PHASES  = 10;
	localparam int         PHASE_REQUESTS = 52;
	localparam int         SETTLE_CYCLES  = 20;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         PRINT_LIMIT    = 40;

	typedef struct packed {
		logic [1:0]        opc;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0]  idx;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] baddr;
		logic [IDX_W-1:0]  bnum;
		logic              bitv;
	} alloc_rsp_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic [1:0]        opcode      = '0;
	logic [ADDR_W-1:0] address     = '0;
	logic [IDX_W-1:0]  block_index = '0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [APB_AW-1:0] paddr       = '0;
	logic [APB_DW-1:0] pwdata      = '0;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic [ADDR_W-1:0] block_address;
	logic [IDX_W-1:0]  block_number;
	logic              bit_value;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bitmap_block_allocator_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.address      (address),
		.block_index  (block_index),
		.done         (done),
		.status       (status),
		.block_address(block_address),
		.block_number (block_number),
		.bit_value    (bit_value),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Bench copy of the allocator: one used bit per block plus the three registers.
	logic [MAP_BLOCKS-1:0] block_used        = '0;
	logic [BASE_W-1:0]     shadow_base       = '0;
	logic [BSIZE_W-1:0]    shadow_block_size = BSIZE_RST;
	logic [BIU_W-1:0]      shadow_bytes      = BIU_RST;

	alloc_req_t requests_to_issue[$];
	alloc_rsp_t outcomes_due[$];

	int mismatch_count   = 0;
	int results_checked  = 0;
	int drain_pauses     = 0;
	int settings_applied = 0;
	int idle_cycles      = 0;
	int op_issued[4]     = '{default: 0};
	int status_due[4]    = '{default: 0};

	// Sender state, owned by the driver block.
	int         gap_left       = 0;
	int         burst_left     = 1;
	bit         hold_for_drain = 1'b0;
	alloc_req_t cur_req        = '0;
	alloc_rsp_t predicted;
	alloc_rsp_t awaited;

	// Byte counts past the map size are clipped to it; zero bytes means no blocks at all.
	function automatic int unsigned active_block_count();
		return ((shadow_bytes > BBA_MAP_BYTES) ? BBA_MAP_BYTES : shadow_bytes) * 8;
	endfunction

	// An address somewhere inside block num under the current base and block size.
	function automatic logic [ADDR_W-1:0] free_address_for(input int unsigned num);
		logic [ADDR_W-1:0] offset;
		offset = '0;
		if (shadow_block_size != 0)
			offset = ADDR_W'($urandom_range(0, shadow_block_size - 1));
		return {1'b0, shadow_base} + ADDR_W'(num) * ADDR_W'(shadow_block_size) + offset;
	endfunction

	// Applies one request to the bench bitmap and returns the result the core must give.
	function automatic alloc_rsp_t bitmap_outcome(input alloc_req_t r);
		alloc_rsp_t  rsp;
		int unsigned nblk;
		logic [63:0] quotient;
		bit          found;
		rsp = '0;
		nblk = active_block_count();
		found = 1'b0;
		case (r.opc)
			OP_ALLOC: begin
				rsp.status = ST_NOSPACE;
				for (int n = 0; n < nblk; n++) begin
					if (!found && !block_used[n]) begin
						found = 1'b1;
						block_used[n] = 1'b1;
						rsp.status = ST_OK;
						rsp.bnum = IDX_W'(n);
						rsp.baddr = {1'b0, shadow_base} + ADDR_W'(n) * ADDR_W'(shadow_block_size);
					end
				end
			end
			OP_FREE: begin
				if (r.addr < {1'b0, shadow_base}) begin
					rsp.status = ST_BELOW;
				end else if (shadow_block_size == 0) begin
					rsp.status = ST_RANGE;
				end else begin
					quotient = 64'(r.addr - {1'b0, shadow_base}) / 64'(shadow_block_size);
					if (quotient >= 64'(nblk)) begin
						rsp.status = ST_RANGE;
					end else begin
						block_used[quotient] = 1'b0;
						rsp.status = ST_OK;
						rsp.bnum = quotient[IDX_W-1:0];
					end
				end
			end
			OP_TEST: begin
				if (32'(r.idx) >= nblk) begin
					rsp.status = ST_RANGE;
				end else begin
					rsp.status = ST_OK;
					rsp.bnum = r.idx;
					rsp.bitv = block_used[r.idx];
				end
			end
			default: rsp.status = ST_RANGE;
		endcase
		return rsp;
	endfunction

	// Every mismatch is counted; printing stops after a while to keep the log short.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("MISMATCH @%0t result %0d: %s", $time, results_checked, what);
	endtask

	task automatic push_request(input logic [1:0] opc, input logic [ADDR_W-1:0] addr,
			input logic [IDX_W-1:0] idx);
		alloc_req_t r;
		r.opc = opc;
		r.addr = addr;
		r.idx = idx;
		requests_to_issue.push_back(r);
	endtask

	// APB write: setup cycle, then access cycle until pready; the bench copy follows.
	task automatic write_register(input cfg_reg_t which, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({which, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (which)
			REG_BASE:         shadow_base = value;
			REG_BLOCK_SIZE:   shadow_block_size = value[BSIZE_W-1:0];
			REG_BYTES_IN_USE: shadow_bytes = value[BIU_W-1:0];
			default:          ;
		endcase
	endtask

	// Polled at the falling edge, where every value of the rising edge has settled.
	task automatic wait_until_drained();
		do @(negedge clk);
		while (requests_to_issue.size() != 0 || outcomes_due.size() != 0 || start || busy);
	endtask

	// Driver: requests go out in bursts with random gaps; now and then the sender holds
	// back until every outstanding request has answered. A request stays on the ports
	// until the core takes it, and its result is predicted at that edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predicted = bitmap_outcome(cur_req);
				outcomes_due.push_back(predicted);
				op_issued[cur_req.opc]++;
				status_due[predicted.status]++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (hold_for_drain && outcomes_due.size() != 0) begin
					start <= 1'b0;
				end else if (requests_to_issue.size() != 0) begin
					if (hold_for_drain)
						drain_pauses++;
					hold_for_drain = 1'b0;
					cur_req = requests_to_issue.pop_front();
					opcode <= cur_req.opc;
					address <= cur_req.addr;
					block_index <= cur_req.idx;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
						hold_for_drain = (drain_pauses == 0) || ($urandom_range(0, 9) == 0);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each strobed result is taken in the cycle it is shown and compared with
	// the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_checked++;
			if (outcomes_due.size() == 0) begin
				report_mismatch("result strobe with no request outstanding");
			end else begin
				awaited = outcomes_due.pop_front();
				if (status !== awaited.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, awaited.status));
				if (block_address !== awaited.baddr)
					report_mismatch($sformatf("block_address 0x%0h, expected 0x%0h",
						block_address, awaited.baddr));
				if (block_number !== awaited.bnum)
					report_mismatch($sformatf("block_number %0d, expected %0d",
						block_number, awaited.bnum));
				if (bit_value !== awaited.bitv)
					report_mismatch($sformatf("bit_value %0b, expected %0b",
						bit_value, awaited.bitv));
			end
		end
	end

	// Watchdog: ends the run when no request, result or register write moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
				$display("bitmap_block_allocator_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		alloc_req_t         r;
		int unsigned        pick;
		int unsigned        sub;
		int unsigned        nblk;
		logic [BASE_W-1:0]  base;
		logic [BSIZE_W-1:0] bsize;
		logic [BIU_W-1:0]   nbytes;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		settings_applied = 1;

		// Reset settings: base 0, 64-byte blocks, the whole map.
		push_request(OP_TEST, '0, 8'd255);          // last block, free after reset
		repeat (3) push_request(OP_ALLOC, '0, '0);  // blocks 0, 1 and 2
		push_request(OP_FREE, 33'd127, '0);         // last byte of block 1
		push_request(OP_FREE, 33'd64, '0);          // block 1 again, already free
		push_request(OP_ALLOC, '0, '0);             // lowest free block is 1 again
		push_request(OP_FREE, '1, '0);              // highest address, far past the map
		push_request(OPC_UNUSED, '1, '1);
		push_request(OP_FREE, 33'd16320, '0);       // block 255, never used
		wait_until_drained();

		// Highest base and block size with a single map byte: addresses carry into
		// bit 32, and the map fills after five more allocations.
		write_register(REG_BASE, 32'hFFFF_FFFF);
		write_register(REG_BLOCK_SIZE, 32'h0000_FFFF);
		write_register(REG_BYTES_IN_USE, 32'd1);
		settings_applied++;
		repeat (6) push_request(OP_ALLOC, '0, '0);
		push_request(OP_FREE, '0, '0);                                   // below base
		push_request(OP_FREE, 33'h0_FFFF_FFFF + 33'd8 * 33'hFFFF, '0);   // past the map
		push_request(OP_FREE, 33'h0_FFFF_FFFF + 33'd2 * 33'hFFFF, '0);   // block 2
		push_request(OP_TEST, '0, 8'd8);                                 // first block past
		wait_until_drained();

		// Empty map: no block exists at all.
		write_register(REG_BYTES_IN_USE, 32'd0);
		settings_applied++;
		push_request(OP_ALLOC, '0, '0);
		push_request(OP_FREE, 33'h0_FFFF_FFFF, '0);
		push_request(OP_TEST, '0, 8'd0);
		wait_until_drained();

		// Zero block size with an oversized byte count, which is clipped to the map.
		write_register(REG_BASE, 32'h0000_1000);
		write_register(REG_BLOCK_SIZE, 32'd0);
		write_register(REG_BYTES_IN_USE, 32'd63);
		settings_applied++;
		push_request(OP_FREE, 33'h1000, '0);
		push_request(OP_ALLOC, '0, '0);
		push_request(OP_TEST, '0, 8'd255);
		wait_until_drained();

		// Random phases: new settings each time, then a mix of requests that is mostly
		// well formed so that allocations and frees churn the bitmap.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0:       base = '0;
				1:       base = 32'hFFFF_FFFF - $urandom_range(0, 32'hF_FFFF);
				2:       base = $urandom;
				default: base = BASE_W'($urandom_range(0, 4095));
			endcase
			case ($urandom_range(0, 7))
				0:       bsize = 16'd1;
				1:       bsize = 16'hFFFF;
				2:       bsize = 16'd1 << $urandom_range(0, 15);
				3:       bsize = '0;
				default: bsize = BSIZE_W'($urandom_range(1, 300));
			endcase
			case ($urandom_range(0, 4))
				0:       nbytes = BIU_W'($urandom_range(1, 3));
				1:       nbytes = 6'd32;
				2:       nbytes = BIU_W'($urandom_range(33, 63));
				default: nbytes = BIU_W'($urandom_range(0, 32));
			endcase
			// Upper data bits are noise that the narrow registers must drop.
			write_register(REG_BASE, base);
			write_register(REG_BLOCK_SIZE, {16'($urandom), bsize});
			write_register(REG_BYTES_IN_USE, {26'($urandom), nbytes});
			settings_applied++;
			nblk = active_block_count();

			repeat (PHASE_REQUESTS) begin
				r.opc = OP_ALLOC;
				r.addr = {1'($urandom_range(0, 1)), 32'($urandom)};
				r.idx = IDX_W'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (pick >= 95) begin
					r.opc = OPC_UNUSED;
				end else if (pick >= 75) begin
					r.opc = OP_TEST;
					if (nblk != 0 && $urandom_range(0, 3) != 0)
						r.idx = IDX_W'($urandom_range(0, nblk - 1));
				end else if (pick >= 40) begin
					r.opc = OP_FREE;
					sub = $urandom_range(0, 9);
					// Low blocks are the ones allocations hand out first.
					if (nblk != 0 && sub < 4)
						r.addr = free_address_for($urandom_range(0,
							((nblk < 16) ? nblk : 16) - 1));
					else if (nblk != 0 && sub < 7)
						r.addr = free_address_for($urandom_range(0, nblk - 1));
					else if (sub == 7 && base != 0)
						r.addr = ADDR_W'($urandom_range(0, base - 1));
					else if (sub == 8)
						r.addr = free_address_for(nblk + $urandom_range(0, 7));
				end
				requests_to_issue.push_back(r);
			end
			wait_until_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Run: %0d allocate, %0d free, %0d test, %0d unused-opcode requests over %0d settings",
			op_issued[OP_ALLOC], op_issued[OP_FREE], op_issued[OP_TEST],
			op_issued[OPC_UNUSED], settings_applied);
		$display("Outcomes: %0d ok, %0d no space, %0d below base, %0d out of range; %0d drain pauses",
			status_due[ST_OK], status_due[ST_NOSPACE], status_due[ST_BELOW],
			status_due[ST_RANGE], drain_pauses);
		if (mismatch_count == 0)
			$display("bitmap_block_allocator_core verification clean");
		else
			$display("bitmap_block_allocator_core verification failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/bba_pkg.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_datapath.sv
hw/rtl/bitmap_block_allocator_core.sv
bench/testbench.sv
